// ----- rtl/dfs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_pkg
// Shared types and constants of the delimited field splitter: byte classes,
// result kinds, register indexes and the word carried from front to back.
// ----------------------------------------------------------------------------
package dfs_pkg;

  // default parameter values
  localparam int MAX_FIELDS_DEF         = 256;
  localparam int FIELD_LENGTH_LIMIT_DEF = 4095;

  // widths fixed by the field definitions
  localparam int BYTE_W  = 8;
  localparam int INDEX_W = 8;
  localparam int CFG_W   = 12;
  localparam int CFG_IDX_W = 2;
  localparam int KIND_W  = 2;
  // width for length compares, covers any limit up to 65535
  localparam int CMP_W   = 17;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COMMA   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPACE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAB     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN = 2'd3;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_BYTE       = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FIELD_END  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RECORD_END = 2'd2;

  // special characters
  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_DQ    = 8'h22;
  localparam logic [BYTE_W-1:0] CH_SQ    = 8'h27;
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;

  // byte class decided by the front
  typedef enum logic [2:0] {
    CLS_OTHER       = 3'd0,
    CLS_SPACE_DELIM = 3'd1,
    CLS_SPACE_PLAIN = 3'd2,
    CLS_REC_END     = 3'd3,
    CLS_DQ          = 3'd4,
    CLS_SQ          = 3'd5,
    CLS_DELIM       = 3'd6
  } cls_t;

  // classified word passed through the queue
  typedef struct packed {
    cls_t              cls;
    logic [BYTE_W-1:0] data;
    logic              start;
  } item_t;

  // delimiter enables
  typedef struct packed {
    logic comma;
    logic space;
    logic tab;
  } delim_cfg_t;

endpackage

// ----- rtl/dfs_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_front
// Input stage: accepts a word, classifies its byte against the enabled
// delimiters and holds the classified word until the queue takes it.
// ----------------------------------------------------------------------------
module dfs_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [dfs_pkg::BYTE_W-1:0]  in_byte,
  input  logic                        in_start,
  input  dfs_pkg::delim_cfg_t         delim_cfg,
  output logic                        push,
  input  logic                        push_ready,
  output dfs_pkg::item_t              push_item
);

  logic           valid;
  dfs_pkg::item_t item;
  dfs_pkg::cls_t  cls_next;

  // byte classification
  always_comb begin
    if (in_byte == dfs_pkg::CH_NUL || in_byte == dfs_pkg::CH_LF ||
        in_byte == dfs_pkg::CH_CR || in_byte == dfs_pkg::CH_FF) begin
      cls_next = dfs_pkg::CLS_REC_END;
    end else if (in_byte == dfs_pkg::CH_SPACE) begin
      cls_next = delim_cfg.space ? dfs_pkg::CLS_SPACE_DELIM : dfs_pkg::CLS_SPACE_PLAIN;
    end else if (in_byte == dfs_pkg::CH_DQ) begin
      cls_next = dfs_pkg::CLS_DQ;
    end else if (in_byte == dfs_pkg::CH_SQ) begin
      cls_next = dfs_pkg::CLS_SQ;
    end else if ((in_byte == dfs_pkg::CH_COMMA && delim_cfg.comma) ||
                 (in_byte == dfs_pkg::CH_TAB && delim_cfg.tab)) begin
      cls_next = dfs_pkg::CLS_DELIM;
    end else begin
      cls_next = dfs_pkg::CLS_OTHER;
    end
  end

  assign in_ready  = !valid || push_ready;
  assign push      = valid;
  assign push_item = item;

  // holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item.cls   <= cls_next;
      item.data  <= in_byte;
      item.start <= in_start;
    end
  end

endmodule

// ----- rtl/dfs_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_queue
// Short first-in first-out queue of classified words between front and back.
// ----------------------------------------------------------------------------
module dfs_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           push_ready,
  input  dfs_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop,
  output dfs_pkg::item_t pop_item
);

  localparam int PTR_W = $clog2(dfs_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(dfs_pkg::QUEUE_DEPTH + 1);

  dfs_pkg::item_t   mem [dfs_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(dfs_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_item   = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(dfs_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(dfs_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/dfs_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_back
// Parser: runs the field state machine on each classified word and loads
// any result into the output register.
// ----------------------------------------------------------------------------
module dfs_back #(
  parameter int MAX_FIELDS         = dfs_pkg::MAX_FIELDS_DEF,
  parameter int FIELD_LENGTH_LIMIT = dfs_pkg::FIELD_LENGTH_LIMIT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [dfs_pkg::CFG_W-1:0]    max_len,
  input  logic                         pop_valid,
  output logic                         pop,
  input  dfs_pkg::item_t               pop_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [dfs_pkg::KIND_W-1:0]   out_kind,
  output logic [dfs_pkg::BYTE_W-1:0]   out_byte,
  output logic [dfs_pkg::INDEX_W-1:0]  out_index,
  output logic                         out_trunc,
  output logic                         out_last
);

  localparam int LEN_W = $clog2(FIELD_LENGTH_LIMIT + 1);
  localparam int IDX_CAP_I = (MAX_FIELDS - 1 > 255) ? 255 : MAX_FIELDS - 1;
  localparam logic [dfs_pkg::INDEX_W-1:0] IDX_CAP = dfs_pkg::INDEX_W'(IDX_CAP_I);
  localparam logic [dfs_pkg::CMP_W-1:0] LEN_LIMIT = dfs_pkg::CMP_W'(FIELD_LENGTH_LIMIT);

  typedef enum logic [4:0] {
    MODE_START = 5'b00001,
    MODE_PLAIN = 5'b00010,
    MODE_DQ    = 5'b00100,
    MODE_SQ    = 5'b01000,
    MODE_DONE  = 5'b10000
  } mode_t;

  mode_t                        mode, mode_next, e_mode;
  logic [LEN_W-1:0]             len, len_next, e_len;
  logic [dfs_pkg::INDEX_W-1:0]  cnt, cnt_next, e_cnt;
  logic                         drop, drop_next, e_drop;
  logic [dfs_pkg::CMP_W-1:0]    len_cap;
  logic                         room;
  logic                         want_keep, want_end, end_last;
  logic                         res_valid;
  logic [dfs_pkg::KIND_W-1:0]   res_kind;
  logic [dfs_pkg::BYTE_W-1:0]   res_byte;
  logic                         res_trunc, res_last;
  dfs_pkg::cls_t                cls;

  assign pop = pop_valid && (!out_valid || out_ready);
  assign cls = pop_item.cls;

  // limit in force and room check
  assign len_cap = (dfs_pkg::CMP_W'(max_len) < LEN_LIMIT) ? dfs_pkg::CMP_W'(max_len) : LEN_LIMIT;
  assign room    = (dfs_pkg::CMP_W'(e_len) < len_cap);

  // state seen by this word, cleared on record start
  always_comb begin
    e_mode = pop_item.start ? MODE_START : mode;
    e_len  = pop_item.start ? '0 : len;
    e_cnt  = pop_item.start ? '0 : cnt;
    e_drop = pop_item.start ? 1'b0 : drop;
  end

  // per-mode decision
  always_comb begin
    want_keep = 1'b0;
    want_end  = 1'b0;
    end_last  = 1'b0;
    mode_next = e_mode;
    res_valid = 1'b0;
    res_kind  = dfs_pkg::KIND_BYTE;
    res_byte  = '0;
    res_trunc = 1'b0;
    res_last  = 1'b0;
    case (e_mode)
      MODE_START: begin
        if (cls inside {dfs_pkg::CLS_SPACE_DELIM, dfs_pkg::CLS_SPACE_PLAIN}) begin
          // leading space skipped
        end else if (cls == dfs_pkg::CLS_REC_END) begin
          mode_next = MODE_DONE;
          res_valid = 1'b1;
          res_kind  = dfs_pkg::KIND_RECORD_END;
          res_last  = 1'b1;
        end else if (cls == dfs_pkg::CLS_DQ) begin
          mode_next = MODE_DQ;
        end else if (cls == dfs_pkg::CLS_SQ) begin
          mode_next = MODE_SQ;
        end else if (cls == dfs_pkg::CLS_DELIM) begin
          want_end = 1'b1;
        end else begin
          mode_next = MODE_PLAIN;
          want_keep = 1'b1;
        end
      end
      MODE_PLAIN: begin
        if (cls == dfs_pkg::CLS_REC_END) begin
          want_end = 1'b1;
          end_last = 1'b1;
        end else if (cls inside {dfs_pkg::CLS_SPACE_DELIM, dfs_pkg::CLS_DELIM}) begin
          want_end = 1'b1;
        end else begin
          want_keep = 1'b1;
        end
      end
      MODE_DQ: begin
        if (cls == dfs_pkg::CLS_REC_END) begin
          want_end = 1'b1;
          end_last = 1'b1;
        end else if (cls == dfs_pkg::CLS_DQ) begin
          mode_next = MODE_PLAIN;
        end else begin
          want_keep = 1'b1;
        end
      end
      MODE_SQ: begin
        if (cls == dfs_pkg::CLS_REC_END) begin
          want_end = 1'b1;
          end_last = 1'b1;
        end else if (cls == dfs_pkg::CLS_SQ) begin
          mode_next = MODE_PLAIN;
        end else begin
          want_keep = 1'b1;
        end
      end
      default: begin
        // record done: bytes ignored until the next record start
      end
    endcase

    len_next  = e_len;
    cnt_next  = e_cnt;
    drop_next = e_drop;

    // keep or drop a field byte
    if (want_keep) begin
      if (room) begin
        len_next  = e_len + LEN_W'(1);
        res_valid = 1'b1;
        res_byte  = pop_item.data;
      end else begin
        drop_next = 1'b1;
      end
    end

    // close the field
    if (want_end) begin
      res_valid = 1'b1;
      res_kind  = dfs_pkg::KIND_FIELD_END;
      res_trunc = e_drop;
      res_last  = end_last;
      len_next  = '0;
      drop_next = 1'b0;
      if (end_last) begin
        mode_next = MODE_DONE;
      end else begin
        mode_next = MODE_START;
        if (e_cnt < IDX_CAP) begin
          cnt_next = e_cnt + dfs_pkg::INDEX_W'(1);
        end
      end
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_START;
      len  <= '0;
      cnt  <= '0;
      drop <= 1'b0;
    end else if (pop) begin
      mode <= mode_next;
      len  <= len_next;
      cnt  <= cnt_next;
      drop <= drop_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= pop && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && res_valid) begin
      out_kind  <= res_kind;
      out_byte  <= res_byte;
      out_index <= e_cnt;
      out_trunc <= res_trunc;
      out_last  <= res_last;
    end
  end

endmodule

// ----- rtl/delimited_field_splitter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_field_splitter
// Splits a stream of record text into fields, one byte per word.
// ----------------------------------------------------------------------------
//  channel  | direction | content
//  s_axis   | in        | tdata: data_byte; tuser: record_start
//  m_axis   | out       | tdata: out_byte, field_index, truncated; tuser: kind;
//           |           | tlast: record_last
//  cfg      | in        | write enable, register index, write data
//
// One input word per cycle while m_axis is not stalled; a word that gives a
// result shows it after the input register, the queue and the output register.
// Synchronous active-high reset clears control state and restores the register
// defaults. A stalled output fills the four-entry queue before s_axis_tready
// drops; words without a result still wait for a free output register.
// ----------------------------------------------------------------------------
module delimited_field_splitter #(
  parameter int MAX_FIELDS         = dfs_pkg::MAX_FIELDS_DEF,
  parameter int FIELD_LENGTH_LIMIT = dfs_pkg::FIELD_LENGTH_LIMIT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [7:0] data_byte
  input  logic [0:0]                      s_axis_tuser,  // [0] record_start
  // output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [23:0]                     m_axis_tdata,  // [7:0] out_byte,
                                                         // [15:8] field_index,
                                                         // [16] truncated
  output logic [1:0]                      m_axis_tuser,  // [1:0] kind
  output logic                            m_axis_tlast,  // record_last
  // configuration
  input  logic                            cfg_we,
  input  logic [dfs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dfs_pkg::CFG_W-1:0]       cfg_data
);

  dfs_pkg::delim_cfg_t           delim_cfg;
  logic [dfs_pkg::CFG_W-1:0]     max_len;
  logic                          push, push_ready, pop_valid, pop;
  dfs_pkg::item_t                push_item, pop_item;
  logic [dfs_pkg::BYTE_W-1:0]    out_byte;
  logic [dfs_pkg::INDEX_W-1:0]   out_index;
  logic                          out_trunc;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      delim_cfg.comma <= 1'b1;
      delim_cfg.space <= 1'b1;
      delim_cfg.tab   <= 1'b1;
      max_len         <= dfs_pkg::CFG_W'(255);
    end else if (cfg_we) begin
      case (cfg_index)
        dfs_pkg::REG_COMMA:   delim_cfg.comma <= cfg_data[0];
        dfs_pkg::REG_SPACE:   delim_cfg.space <= cfg_data[0];
        dfs_pkg::REG_TAB:     delim_cfg.tab   <= cfg_data[0];
        dfs_pkg::REG_MAX_LEN: max_len         <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // front: accept and classify
  dfs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .in_start   (s_axis_tuser[0]),
    .delim_cfg  (delim_cfg),
    .push       (push),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // queue between front and back
  dfs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_item   (pop_item)
  );

  // back: parse and emit
  dfs_back #(
    .MAX_FIELDS         (MAX_FIELDS),
    .FIELD_LENGTH_LIMIT (FIELD_LENGTH_LIMIT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .max_len   (max_len),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_item  (pop_item),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_kind  (m_axis_tuser),
    .out_byte  (out_byte),
    .out_index (out_index),
    .out_trunc (out_trunc),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, out_trunc, out_index, out_byte};

endmodule
